### hw/rtl/b58_pkg.sv
// shared types, constants and the character table of the base-58 converter
// no dependencies
`default_nettype none

package b58_pkg;

  // radix and the reciprocal used to divide a 32-bit value by it
  localparam int unsigned RADIX      = 58;
  localparam int unsigned RECIP_SH   = 37;
  localparam logic [31:0] RECIP_MUL  = 32'h8D3D_CB09;  // ceil(2^37 / 58)
  localparam int unsigned MAX_OUT    = 6;              // most characters per value

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_t;

  // quotient and remainder from the divide unit
  typedef struct packed {
    logic [31:0] quot;
    logic [5:0]  rem;
  } div_res_t;

  // digit to ascii, digits beyond the alphabet saturate to its last character
  function automatic logic [6:0] char_of(input logic [5:0] d);
    logic [6:0] dd;
    logic [6:0] c;
    dd = {1'b0, d};
    if (d < 6'd9) begin
      c = 7'd49 + dd;               // '1'..'9'
    end else if (d < 6'd20) begin
      c = 7'd97 + dd - 7'd9;        // 'a'..'k'
    end else if (d < 6'd34) begin
      c = 7'd109 + dd - 7'd20;      // 'm'..'z'
    end else if (d < 6'd42) begin
      c = 7'd65 + dd - 7'd34;       // 'A'..'H'
    end else if (d < 6'd47) begin
      c = 7'd74 + dd - 7'd42;       // 'J'..'N'
    end else if (d < 6'd58) begin
      c = 7'd80 + dd - 7'd47;       // 'P'..'Z'
    end else begin
      c = 7'd90;                    // 'Z'
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/b58_div58.sv
// shared divide-by-58 unit: registered reciprocal multiply, then remainder fix
// depends on b58_pkg
`default_nettype none

module b58_div58 (
  input  wire logic             clk,
  input  wire logic             start,
  input  wire logic [31:0]      dividend,
  output b58_pkg::div_res_t     res
);
  import b58_pkg::*;

  logic [31:0] x_r;
  logic [63:0] prod_r;
  logic [31:0] q_est;
  logic [31:0] q_x58;
  logic [31:0] r_est;

  // reciprocal multiply, registered
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= dividend;
      prod_r <= dividend * RECIP_MUL;
    end
  end

  // quotient from the high product bits, remainder by shift and add
  always_comb begin
    q_est = {5'd0, prod_r[63:RECIP_SH]};
    q_x58 = (q_est << 5) + (q_est << 4) + (q_est << 3) + (q_est << 1);
    r_est = x_r - q_x58;
    if (r_est >= 32'(RADIX)) begin
      res.quot = q_est + 32'd1;
      res.rem  = 6'(r_est - 32'(RADIX));
    end else begin
      res.quot = q_est;
      res.rem  = r_est[5:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/base58_integer_to_text.sv
// top level of the base-58 converter: sequencer, digit store, output register
// depends on b58_pkg and b58_div58
//
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_number_in[31:0]  | request in
//  out     | out_valid, out_stall, out_char_code[6:0], | request out
//          | out_last_char                           |
//
// each divide step runs in the shared reciprocal multiplier unit, through the
// DIV state, where the product is registered, and the FIX state, where the
// remainder is stored; then out takes one character per cycle unless stalled.
// in_stall stays high from the accepted request until the last character is
// loaded into the output register; a stall on out holds the sequencer in emit.
// synchronous active-low reset returns the sequencer to idle and empties out.
`default_nettype none

module base58_integer_to_text #(
  parameter int unsigned MAX_DIGITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_number_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_char_code,
  output logic             out_last_char
);
  import b58_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

  state_t            state_r, state_nxt;
  logic [31:0]       quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [5:0]        dig_r [MAX_DIGITS];
  logic              dig_we;
  logic [5:0]        dig_wdata;
  logic              div_start;
  div_res_t          div_res;
  logic              more_div;
  logic              out_free;
  logic              load;
  logic [CNT_W-1:0]  n_out;
  logic [CNT_W-1:0]  rd_idx;
  logic              is_last;
  logic              out_valid_r;
  logic [6:0]        char_r;
  logic              last_r;

  b58_div58 u_div (
    .clk      (clk),
    .start    (div_start),
    .dividend (quot_r),
    .res      (div_res)
  );

  // loop condition, character count and read index
  always_comb begin
    more_div = (quot_r >= 32'(RADIX)) && ((cnt_r + CNT_W'(1)) < CNT_W'(MAX_DIGITS));
    n_out    = (cnt_r > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : cnt_r;
    rd_idx   = cnt_r - CNT_W'(1) - k_r;
    is_last  = (k_r + CNT_W'(1)) == n_out;
    out_free = !out_valid_r || !out_stall;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = more_div ? ST_FIX : ST_EMIT;
      ST_FIX:  state_nxt = ST_DIV;
      ST_EMIT: if (out_free && is_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    div_start = 1'b0;
    dig_we    = 1'b0;
    dig_wdata = div_res.rem;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          quot_nxt = in_number_in;
          cnt_nxt  = '0;
        end
      end
      ST_DIV: begin
        if (more_div) begin
          div_start = 1'b1;
        end else begin
          // leading digit, saturated when the digit limit cut the loop short
          dig_we    = 1'b1;
          dig_wdata = (quot_r >= 32'(RADIX)) ? 6'(RADIX - 1) : quot_r[5:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
          k_nxt     = '0;
        end
      end
      ST_FIX: begin
        dig_we   = 1'b1;
        quot_nxt = div_res.quot;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          load  = 1'b1;
          k_nxt = k_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      quot_r      <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      quot_r  <= quot_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[cnt_r[IDX_W-1:0]] <= dig_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_of(dig_r[rd_idx[IDX_W-1:0]]);
      last_r <= is_last;
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

endmodule

`default_nettype wire

### hw/rtl/b58_checker.sv
// port-level checks of the base-58 converter and their bind to the top level
// depends on base58_integer_to_text
`default_nettype none

module b58_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [6:0]  out_char_code,
  input wire logic        out_last_char
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled output character changed");

  // a new request is not taken in the cycle after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a conversion runs");

  // while a character other than the last is taken from out, no new request is taken
  a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_char |-> in_stall)
    else $error("input taken before the last character");

  // reset empties the output and leaves the block ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left output valid or input stalled");

endmodule

bind base58_integer_to_text b58_checker u_b58_checker (.*);

`default_nettype wire
